### rtl/mms_pkg.sv
// Shared types, constants and control program for the mean/median/mode statistics block.
package mms_pkg;

    localparam int NUM_BINS = 10;
    localparam int IDX_W = 4;
    localparam int VAL_W = 4;
    localparam logic [VAL_W-1:0] DIGIT_MAX = 4'd9;

    localparam int MEAN_W = 12;
    localparam int MED_W = 5;
    localparam int MCNT_W = 4;
    localparam int FREQ_W = 11;

    // mean = sum * 2^FRAC_W / n, quotient fits QUOT_W bits
    localparam int QUOT_W = 12;
    localparam int FRAC_W = 8;
    localparam int DCNT_W = 4;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    // program step addresses
    localparam pc_t P_LOAD  = 3'd0;
    localparam pc_t P_SETUP = 3'd1;
    localparam pc_t P_RDLO  = 3'd2;
    localparam pc_t P_CAPLO = 3'd3;
    localparam pc_t P_DIV   = 3'd4;
    localparam pc_t P_SCAN  = 3'd5;
    localparam pc_t P_EMIT  = 3'd6;
    localparam pc_t P_CLEAR = 3'd7;

    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_WAIT_LAST = 3'd2,
        C_LOOP_DIV  = 3'd3,
        C_LOOP_SCAN = 3'd4
    } cond_t;

    typedef struct packed {
        logic  ready;
        logic  div_init;
        logic  div_step;
        logic  rd_hi;
        logic  rd_lo;
        logic  cap_hi;
        logic  cap_lo;
        logic  scan_init;
        logic  scan_step;
        logic  emit;
        logic  clear;
        cond_t cond;
        pc_t   target;
    } ctl_word_t;

    typedef struct packed {
        logic last_acc;
        logic div_more;
        logic scan_more;
        logic stall;
    } seq_stat_t;

    function automatic ctl_word_t prog_rom(pc_t pc);
        ctl_word_t w;
        w = '0;
        w.cond = C_NEXT;
        w.target = P_LOAD;
        case (pc)
            P_LOAD:
            begin
                w.ready = 1'b1;
                w.cond = C_WAIT_LAST;
            end
            P_SETUP:
            begin
                w.div_init = 1'b1;
                w.rd_hi = 1'b1;
                w.scan_init = 1'b1;
            end
            P_RDLO:
            begin
                w.cap_hi = 1'b1;
                w.rd_lo = 1'b1;
            end
            P_CAPLO:
            begin
                w.cap_lo = 1'b1;
            end
            P_DIV:
            begin
                w.div_step = 1'b1;
                w.cond = C_LOOP_DIV;
                w.target = P_DIV;
            end
            P_SCAN:
            begin
                w.scan_step = 1'b1;
                w.cond = C_LOOP_SCAN;
                w.target = P_SCAN;
            end
            P_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = C_LOOP_SCAN;
                w.target = P_EMIT;
            end
            P_CLEAR:
            begin
                w.clear = 1'b1;
                w.cond = C_ALWAYS;
                w.target = P_LOAD;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.target = P_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/mms_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module mms_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mms_pkg::seq_stat_t    stat,
    output mms_pkg::ctl_word_t    ctl
);
    import mms_pkg::*;

    pc_t pc_reg;
    pc_t pc_next;

    assign ctl = prog_rom(pc_reg);

    always_comb
    begin
        pc_next = pc_t'(pc_reg + 1'b1);
        if (stat.stall)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            case (ctl.cond)
                C_NEXT:
                begin
                    pc_next = pc_t'(pc_reg + 1'b1);
                end
                C_ALWAYS:
                begin
                    pc_next = ctl.target;
                end
                C_WAIT_LAST:
                begin
                    if (!stat.last_acc)
                        pc_next = pc_reg;
                end
                C_LOOP_DIV:
                begin
                    if (stat.div_more)
                        pc_next = ctl.target;
                end
                C_LOOP_SCAN:
                begin
                    if (stat.scan_more)
                        pc_next = ctl.target;
                end
                default:
                begin
                    pc_next = P_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= P_LOAD;
        else
            pc_reg <= pc_next;
    end

endmodule

### rtl/mean_median_mode_stats.sv
// Top level: digit-set statistics (mean, median, modes) driven by a microcoded sequencer.
//
// Usage:
//   Input stream (s_axis_*): one digit per transaction in tdata[3:0]; tlast
//   closes the set. Digits above nine count as nine. Values beyond
//   MAX_ITEMS are dropped, but a dropped value with tlast still closes the set.
//   Output stream (m_axis_*): one transaction per mode value, ascending, each
//   carrying mean*256 (truncated), twice the median, mode count and highest
//   frequency; tlast marks the final mode of the set.
// Sequence:
//   Loading takes one value per cycle. After the closing transaction the
//   program runs the setup steps (setup, high read, low capture), a restoring
//   divider for the mean, a histogram scan, an emit pass and a clear step,
//   then raises s_axis_tready again; the emit pass waits while the receiver
//   stalls.
// Reset: histogram, sum, count, output valid and the step counter clear at
//   once; the value store needs no clearing, so no pass follows reset.
// Stall: a held output register freezes the emit step at a mode bin until it is taken.
module mean_median_mode_stats
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] sample_value, [7:4] zero
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [11:0] mean_fixed, [16:12] median_doubled,
                                        // [20:17] mode_count, [31:21] max_frequency,
                                        // [35:32] mode_value, [39:36] zero
    output logic        m_axis_tlast    // last_result
);
    import mms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUM_W  = $clog2(int'(DIGIT_MAX) * MAX_ITEMS + 1);
    localparam int REM_W  = CNT_W + 1;
    localparam int HI_SH  = QUOT_W - FRAC_W;

    ctl_word_t ctl;
    seq_stat_t stat;

    // sequencer
    mms_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // load path
    logic             in_acc;
    logic [VAL_W-1:0] raw_val;
    logic [VAL_W-1:0] val_sat;
    logic             room;

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] bins_reg [NUM_BINS];

    logic [VAL_W-1:0] mem [MAX_ITEMS];
    logic [VAL_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] hi_addr;
    logic [ADDR_W-1:0] lo_addr;

    assign s_axis_tready = ctl.ready;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign raw_val = s_axis_tdata[VAL_W-1:0];
    assign val_sat = (raw_val > DIGIT_MAX) ? DIGIT_MAX : raw_val;
    assign room    = (count_reg < CNT_W'(MAX_ITEMS));

    assign hi_addr = ADDR_W'(count_reg >> 1);
    assign lo_addr = ADDR_W'(hi_addr - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            for (int b = 0; b < NUM_BINS; b++)
                bins_reg[b] <= '0;
        end
        else if (ctl.clear)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            for (int b = 0; b < NUM_BINS; b++)
                bins_reg[b] <= '0;
        end
        else if (in_acc && room)
        begin
            count_reg <= CNT_W'(count_reg + 1'b1);
            sum_reg   <= SUM_W'(sum_reg + SUM_W'(val_sat));
            for (int b = 0; b < NUM_BINS; b++)
            begin
                if (val_sat == VAL_W'(b))
                    bins_reg[b] <= CNT_W'(bins_reg[b] + 1'b1);
            end
        end
    end

    // value store, one write and one read port
    always_ff @(posedge clk)
    begin
        if (in_acc && room)
            mem[count_reg[ADDR_W-1:0]] <= val_sat;
        if (ctl.rd_hi)
            rdata_reg <= mem[hi_addr];
        else if (ctl.rd_lo)
            rdata_reg <= mem[lo_addr];
    end

    // median
    logic [VAL_W-1:0] med_hi_reg;
    logic [VAL_W-1:0] med_lo_reg;
    logic [MED_W-1:0] median;

    assign median = count_reg[0] ? {med_hi_reg, 1'b0}
                                 : MED_W'(med_hi_reg) + MED_W'(med_lo_reg);

    // restoring divider: sum * 256 / count, one quotient bit per step
    logic [REM_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  denom;
    logic              fits;

    assign denom = {1'b0, count_reg};
    assign trial = {rem_reg[REM_W-2:0], dsh_reg[QUOT_W-1]};
    assign fits  = (trial >= denom);

    // histogram scan and emit
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_adv;
    logic [CNT_W-1:0]  high_reg;
    logic [MCNT_W-1:0] mcnt_reg;
    logic [MCNT_W-1:0] em_reg;
    logic [CNT_W-1:0]  cur_bin;
    logic              is_mode;
    logic              out_busy;
    logic              stall;
    logic              out_load;

    assign cur_bin  = bins_reg[idx_reg];
    assign idx_adv  = (idx_reg == IDX_W'(NUM_BINS - 1)) ? '0 : IDX_W'(idx_reg + 1'b1);
    assign is_mode  = (high_reg != '0) && (cur_bin == high_reg);
    assign out_busy = m_axis_tvalid && !m_axis_tready;
    assign stall    = ctl.emit && is_mode && out_busy;
    assign out_load = ctl.emit && is_mode && !out_busy;

    assign stat.last_acc  = in_acc && s_axis_tlast;
    assign stat.div_more  = (dcnt_reg != '0);
    assign stat.scan_more = (idx_reg != IDX_W'(NUM_BINS - 1));
    assign stat.stall     = stall;

    always_ff @(posedge clk)
    begin
        if (ctl.cap_hi)
            med_hi_reg <= rdata_reg;
        if (ctl.cap_lo)
            med_lo_reg <= rdata_reg;

        if (ctl.div_init)
        begin
            rem_reg  <= REM_W'(sum_reg >> HI_SH);
            dsh_reg  <= {sum_reg[HI_SH-1:0], FRAC_W'(0)};
            quot_reg <= '0;
            dcnt_reg <= DCNT_W'(QUOT_W - 1);
        end
        else if (ctl.div_step)
        begin
            rem_reg  <= fits ? REM_W'(trial - denom) : trial;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
            dsh_reg  <= {dsh_reg[QUOT_W-2:0], 1'b0};
            dcnt_reg <= DCNT_W'(dcnt_reg - 1'b1);
        end

        if (ctl.scan_init)
        begin
            idx_reg  <= '0;
            high_reg <= '0;
            mcnt_reg <= '0;
            em_reg   <= '0;
        end
        else if (ctl.scan_step)
        begin
            idx_reg <= idx_adv;
            if (cur_bin > high_reg)
            begin
                high_reg <= cur_bin;
                mcnt_reg <= MCNT_W'(1);
            end
            else if (cur_bin == high_reg)
            begin
                mcnt_reg <= MCNT_W'(mcnt_reg + 1'b1);
            end
        end
        else if (ctl.emit && !stall)
        begin
            idx_reg <= idx_adv;
            if (is_mode)
                em_reg <= MCNT_W'(em_reg + 1'b1);
        end
    end

    // output register
    logic              out_valid_reg;
    logic [MEAN_W-1:0] o_mean_reg;
    logic [MED_W-1:0]  o_med_reg;
    logic [MCNT_W-1:0] o_mcnt_reg;
    logic [FREQ_W-1:0] o_freq_reg;
    logic [VAL_W-1:0]  o_val_reg;
    logic              o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_mean_reg <= MEAN_W'(quot_reg);
            o_med_reg  <= median;
            o_mcnt_reg <= mcnt_reg;
            o_freq_reg <= FREQ_W'(high_reg);
            o_val_reg  <= VAL_W'(idx_reg);
            o_last_reg <= (MCNT_W'(em_reg + 1'b1) == mcnt_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {4'b0000, o_val_reg, o_freq_reg, o_mcnt_reg, o_med_reg, o_mean_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond store depth");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sum_reg) <= 32'(count_reg) * 32'(DIGIT_MAX))
        else $error("running sum exceeds nine per counted item");

    a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result offered right after the final mode of a set");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (em_reg <= mcnt_reg))
        else $error("more modes emitted than counted");
`endif

endmodule
